@@ rtl/ordered_pair_list_table_macros.svh @@
// assertion macros for the ordered pair list table
`ifndef ORDERED_PAIR_LIST_TABLE_MACROS_SVH
`define ORDERED_PAIR_LIST_TABLE_MACROS_SVH

// antecedent implies consequent in the same cycle
`define OLT_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define OLT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

// expression never holds
`define OLT_ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) !(expr)) \
        else $error("assertion failed");

`endif

@@ rtl/olt_pkg.sv @@
// shared constants and types of the ordered pair list table
`default_nettype none
package olt_pkg;

    localparam int DEPTH = 16;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int KEY_W = 16;
    localparam int POS_W = 4;
    localparam int OUT_CNT_W = 5;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_REMOVE = 2'd1,
        CMD_QUERY  = 2'd2,
        CMD_READ   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_FULL     = 2'd1,
        ST_NO_MATCH = 2'd2,
        ST_RANGE    = 2'd3
    } t_status;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctl;

endpackage
`default_nettype wire

@@ rtl/olt_cell.sv @@
// one cell of the list: holds a pair, compares it and shifts with its neighbors
`default_nettype none
module olt_cell (
    input  wire logic                      i_clk,
    input  wire olt_pkg::t_cell_ctl        i_ctl,
    input  wire logic                      i_valid,
    input  wire logic [olt_pkg::KEY_W-1:0] i_key_length,
    input  wire logic [olt_pkg::KEY_W-1:0] i_key_width,
    input  wire logic [olt_pkg::KEY_W-1:0] i_prev_length,
    input  wire logic [olt_pkg::KEY_W-1:0] i_prev_width,
    input  wire logic [olt_pkg::KEY_W-1:0] i_next_length,
    input  wire logic [olt_pkg::KEY_W-1:0] i_next_width,
    input  wire logic                      i_seen,
    output logic                           o_seen,
    output logic [olt_pkg::KEY_W-1:0]      o_length,
    output logic [olt_pkg::KEY_W-1:0]      o_width
);

    logic [olt_pkg::KEY_W-1:0] r_length;
    logic [olt_pkg::KEY_W-1:0] r_width;
    logic                      w_match;

    assign w_match  = i_valid && (r_length == i_key_length) && (r_width == i_key_width);
    assign o_seen   = i_seen || w_match;
    assign o_length = r_length;
    assign o_width  = r_width;

    always_ff @(posedge i_clk) begin
        if (i_ctl.insert) begin
            r_length <= i_prev_length;
            r_width  <= i_prev_width;
        end else if (i_ctl.remove && o_seen) begin
            r_length <= i_next_length;
            r_width  <= i_next_width;
        end
    end

endmodule
`default_nettype wire

@@ rtl/ordered_pair_list_table.sv @@
// top level of the ordered pair list table
// A command is taken when start is high and busy is low. The next cycle busy is
// high while the row of cells compares every stored pair against the key and
// shifts in one pass; the cycle after that the result is on the o_ ports for
// exactly one cycle with o_valid high, and a new command may be started in that
// same cycle. A command thus passes through the compare and shift pass of the
// cell row followed by the result register. The receiver cannot stall results.
// o_entry_count and o_is_empty always show the current fill of the list.
`default_nettype none
module ordered_pair_list_table (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [1:0]                    i_cmd,
    input  wire logic [olt_pkg::KEY_W-1:0]     i_key_length,
    input  wire logic [olt_pkg::KEY_W-1:0]     i_key_width,
    input  wire logic [olt_pkg::POS_W-1:0]     i_position,
    output logic                               o_valid,
    output logic [1:0]                         o_status,
    output logic                               o_found,
    output logic [olt_pkg::KEY_W-1:0]          o_read_length,
    output logic [olt_pkg::KEY_W-1:0]          o_read_width,
    output logic [olt_pkg::OUT_CNT_W-1:0]      o_entry_count,
    output logic                               o_is_empty
);

    `include "ordered_pair_list_table_macros.svh"

    logic                           r_busy;
    logic                           r_valid;
    olt_pkg::t_cmd                  r_cmd;
    logic [olt_pkg::KEY_W-1:0]      r_key_length;
    logic [olt_pkg::KEY_W-1:0]      r_key_width;
    logic [olt_pkg::POS_W-1:0]      r_pos;
    logic [olt_pkg::CNT_W-1:0]      r_count;
    olt_pkg::t_status               r_status;
    logic                           r_found;
    logic [olt_pkg::KEY_W-1:0]      r_read_length;
    logic [olt_pkg::KEY_W-1:0]      r_read_width;

    olt_pkg::t_status               n_status;
    logic                           n_found;
    logic [olt_pkg::KEY_W-1:0]      n_read_length;
    logic [olt_pkg::KEY_W-1:0]      n_read_width;
    logic [olt_pkg::CNT_W-1:0]      n_count;

    olt_pkg::t_cell_ctl             w_ctl;
    logic                           w_full;
    logic                           w_pos_ok;
    logic [olt_pkg::IDX_W-1:0]      w_idx;
    logic [olt_pkg::KEY_W-1:0]      w_len [olt_pkg::DEPTH];
    logic [olt_pkg::KEY_W-1:0]      w_wid [olt_pkg::DEPTH];
    logic                           w_seen [olt_pkg::DEPTH+1];

    assign w_full   = (r_count == olt_pkg::CNT_W'(olt_pkg::DEPTH));
    assign w_pos_ok = (32'(r_pos) < 32'(r_count));
    assign w_idx    = olt_pkg::IDX_W'(r_pos);
    assign w_ctl.insert = r_busy && (r_cmd == olt_pkg::CMD_INSERT) && !w_full;
    assign w_ctl.remove = r_busy && (r_cmd == olt_pkg::CMD_REMOVE);
    assign w_seen[0] = 1'b0;

    for (genvar g = 0; g < olt_pkg::DEPTH; g++) begin : g_cell
        logic [olt_pkg::KEY_W-1:0] w_prev_len, w_prev_wid, w_next_len, w_next_wid;
        logic                      w_cell_valid;

        assign w_cell_valid = (olt_pkg::CNT_W'(g) < r_count);
        if (g == 0) begin : g_front
            assign w_prev_len = r_key_length;
            assign w_prev_wid = r_key_width;
        end else begin : g_mid
            assign w_prev_len = w_len[g-1];
            assign w_prev_wid = w_wid[g-1];
        end
        if (g == olt_pkg::DEPTH - 1) begin : g_back
            assign w_next_len = w_len[g];
            assign w_next_wid = w_wid[g];
        end else begin : g_inner
            assign w_next_len = w_len[g+1];
            assign w_next_wid = w_wid[g+1];
        end

        olt_cell u_cell (
            .i_clk         (i_clk),
            .i_ctl         (w_ctl),
            .i_valid       (w_cell_valid),
            .i_key_length  (r_key_length),
            .i_key_width   (r_key_width),
            .i_prev_length (w_prev_len),
            .i_prev_width  (w_prev_wid),
            .i_next_length (w_next_len),
            .i_next_width  (w_next_wid),
            .i_seen        (w_seen[g]),
            .o_seen        (w_seen[g+1]),
            .o_length      (w_len[g]),
            .o_width       (w_wid[g])
        );
    end

    always_comb begin
        n_status      = olt_pkg::ST_OK;
        n_found       = 1'b0;
        n_read_length = '0;
        n_read_width  = '0;
        n_count       = r_count;
        case (r_cmd)
            olt_pkg::CMD_INSERT: begin
                if (w_full) begin
                    n_status = olt_pkg::ST_FULL;
                end else begin
                    n_count = r_count + olt_pkg::CNT_W'(1);
                end
            end
            olt_pkg::CMD_REMOVE: begin
                if (w_seen[olt_pkg::DEPTH]) begin
                    n_count = r_count - olt_pkg::CNT_W'(1);
                end else begin
                    n_status = olt_pkg::ST_NO_MATCH;
                end
            end
            olt_pkg::CMD_QUERY: begin
                n_found = w_seen[olt_pkg::DEPTH];
            end
            olt_pkg::CMD_READ: begin
                if (w_pos_ok) begin
                    n_read_length = w_len[w_idx];
                    n_read_width  = w_wid[w_idx];
                end else begin
                    n_status = olt_pkg::ST_RANGE;
                end
            end
            default: begin
                n_status = olt_pkg::ST_OK;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy  <= 1'b0;
            r_valid <= 1'b0;
            r_count <= '0;
        end else begin
            r_valid <= r_busy;
            if (r_busy) begin
                r_busy  <= 1'b0;
                r_count <= n_count;
            end else if (start) begin
                r_busy  <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_busy && start) begin
            r_cmd        <= olt_pkg::t_cmd'(i_cmd);
            r_key_length <= i_key_length;
            r_key_width  <= i_key_width;
            r_pos        <= i_position;
        end
        if (r_busy) begin
            r_status      <= n_status;
            r_found       <= n_found;
            r_read_length <= n_read_length;
            r_read_width  <= n_read_width;
        end
    end

    assign busy          = r_busy;
    assign o_valid       = r_valid;
    assign o_status      = r_status;
    assign o_found       = r_found;
    assign o_read_length = r_read_length;
    assign o_read_width  = r_read_width;
    assign o_entry_count = olt_pkg::OUT_CNT_W'(r_count);
    assign o_is_empty    = (r_count == '0);

    `OLT_ASSERT_NEXT(a_busy_then_result, i_clk, i_rst_n, busy, o_valid)
    `OLT_ASSERT_NEVER(a_no_result_while_busy, i_clk, i_rst_n, busy && o_valid)
    `OLT_ASSERT_IMPLY(a_full_means_depth, i_clk, i_rst_n,
        o_valid && (o_status == olt_pkg::ST_FULL),
        r_count == olt_pkg::CNT_W'(olt_pkg::DEPTH))
    `OLT_ASSERT_IMPLY(a_no_match_keeps_count, i_clk, i_rst_n,
        o_valid && (o_status == olt_pkg::ST_NO_MATCH),
        r_count == $past(r_count))

endmodule
`default_nettype wire
